// File: sv/poc_pkg.sv
// Shared types and constants for the path obstacle collision check.
`default_nettype none
package poc_pkg;

  // Clamped axis magnitude and squared distance widths
  localparam int MAG_W = 17;
  localparam int SQ_W = 34;
  localparam logic [MAG_W-1:0] AXIS_CLAMP = 17'h10000;

  // Distance thresholds, squared, in 1/65536 m^2
  localparam logic [SQ_W-1:0] NEAR_LIMIT_SQ = 34'd802816;    // 3.5 m
  localparam logic [SQ_W-1:0] LEADER_LIMIT_SQ = 34'd262144;  // 2.0 m

  // Square root: radicand below 3.5 m squared fits in 20 bits
  localparam int ROOT_W = 20;
  localparam logic [ROOT_W-1:0] ROOT_BIT0 = 20'h40000;
  localparam int RES_W = 10;

  // Divide by three as multiply by reciprocal, exact for inputs below 2048
  localparam logic [RES_W-1:0] RECIP3 = 10'd683;
  localparam int RECIP_SHIFT = 11;
  localparam int INC_W = 9;

  localparam int COST_W = 32;
  localparam int CD_W = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLL_DIST = 2'd0,
    REG_FOLLOW    = 2'd1,
    REG_LEADER_X  = 2'd2,
    REG_LEADER_Y  = 2'd3
  } cfg_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SQX,
    OP_SQY,
    OP_LSX,
    OP_LSY,
    OP_CDSQ,
    OP_ROOT,
    OP_DIV,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } poc_cmd_t;

  typedef struct packed {
    logic skip;
    logic root_last;
    logic last;
  } poc_stat_t;

endpackage
`default_nettype wire

// File: sv/poc_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
`default_nettype none
module poc_ctrl
  import poc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire poc_stat_t st,
  output poc_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_LSX,
    S_LSY,
    S_CDSQ,
    S_ROOT,
    S_DIV,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   emit_load;

  assign accept = in_valid && in_ready_r;
  assign emit_load = (state_r == S_EMIT) && st.last && (!out_valid_r || out_ready);

  // Next state and registered handshake outputs
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = st.skip ? S_EMIT : S_SQX;
        end
      end
      S_SQX:    state_nxt = S_SQY;
      S_SQY:    state_nxt = S_LSX;
      S_LSX:    state_nxt = S_LSY;
      S_LSY:    state_nxt = S_CDSQ;
      S_CDSQ:   state_nxt = S_ROOT;
      S_ROOT: begin
        if (st.root_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:    state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!st.last || emit_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Map state to datapath operation
  always_comb begin
    cmd.accept = accept;
    case (state_r)
      S_SQX:    cmd.op = OP_SQX;
      S_SQY:    cmd.op = OP_SQY;
      S_LSX:    cmd.op = OP_LSX;
      S_LSY:    cmd.op = OP_LSY;
      S_CDSQ:   cmd.op = OP_CDSQ;
      S_ROOT:   cmd.op = OP_ROOT;
      S_DIV:    cmd.op = OP_DIV;
      S_UPDATE: cmd.op = OP_UPDATE;
      S_EMIT:   cmd.op = emit_load ? OP_EMIT : OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  assign in_ready = in_ready_r;
  assign out_valid = out_valid_r;

  // A transaction that continues a collided run goes straight to the result step
  a_skip_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st.skip) |=> (state_r == S_EMIT))
    else $error("skipped transaction did not go to emit");

  // A new result only appears out of the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

  // The root iteration only leaves on its final step
  a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && !st.root_last) |=> (state_r == S_ROOT))
    else $error("root iteration left early");

  // No input taken while a transaction is in progress
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready_r)
    else $error("ready while busy");

endmodule
`default_nettype wire

// File: sv/poc_dpath.sv
// Datapath: configuration registers, shared multiplier, root unit and cost state.
`default_nettype none
module poc_dpath
  import poc_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic signed [COORD_WIDTH-1:0] in_path_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_path_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_centre_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_centre_y,
  input  wire logic [COST_W-1:0]             in_base_cost,
  input  wire logic                          in_first_pair,
  input  wire logic                          in_last_pair,
  output logic                               out_collided,
  output logic [COST_W-1:0]                  out_path_cost,
  input  wire poc_cmd_t                      cmd,
  output poc_stat_t                          st
);

  localparam int DW = COORD_WIDTH + 1;

  // Clamped absolute difference of two coordinates
  function automatic logic [MAG_W-1:0] clamp_mag(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    d = DW'(a) - DW'(b);
    m = d[DW-1] ? DW'(-d) : DW'(d);
    clamp_mag = (m > DW'(AXIS_CLAMP)) ? AXIS_CLAMP : m[MAG_W-1:0];
  endfunction

  // Configuration
  logic [CD_W-1:0]               cd_r;
  logic                          follow_r;
  logic signed [COORD_WIDTH-1:0] leader_x_r;
  logic signed [COORD_WIDTH-1:0] leader_y_r;

  // Working registers
  logic [MAG_W-1:0]  mx_r, my_r, lx_r, ly_r;
  logic [SQ_W-1:0]   d2_r, l2_r;
  logic [SQ_W-1:0]   cd2_r;
  logic [ROOT_W-1:0] rad_r, res_r, bit_r;
  logic [INC_W-1:0]  inc_r;
  logic              last_r;

  // Run state
  logic [COST_W-1:0] cost_r;
  logic              hit_r;

  logic [MAG_W-1:0]        mul_a;
  logic [SQ_W-1:0]         prod;
  logic [ROOT_W-1:0]       trial;
  logic [2*RES_W-1:0]      quot_prod;
  logic [COST_W:0]         cost_sum;
  logic                    near_leader;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r       <= CD_W'(512);
      follow_r   <= 1'b0;
      leader_x_r <= '0;
      leader_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLL_DIST: cd_r <= cfg_data[CD_W-1:0];
        REG_FOLLOW:    follow_r <= cfg_data[0];
        REG_LEADER_X:  leader_x_r <= cfg_data;
        REG_LEADER_Y:  leader_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the shared multiplier operand; it squares
  always_comb begin
    case (cmd.op)
      OP_SQX:  mul_a = mx_r;
      OP_SQY:  mul_a = my_r;
      OP_LSX:  mul_a = lx_r;
      OP_LSY:  mul_a = ly_r;
      OP_CDSQ: mul_a = MAG_W'(cd_r);
      default: mul_a = '0;
    endcase
  end

  assign prod = SQ_W'(mul_a) * SQ_W'(mul_a);
  assign trial = res_r + bit_r;
  assign quot_prod = (2*RES_W)'(res_r[RES_W-1:0]) * (2*RES_W)'(RECIP3);
  assign cost_sum = {1'b0, cost_r} + (COST_W + 1)'(inc_r);
  assign near_leader = follow_r && (l2_r < LEADER_LIMIT_SQ);

  // Capture operands on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mx_r   <= clamp_mag(in_path_x, in_corner_x);
      my_r   <= clamp_mag(in_path_y, in_corner_y);
      lx_r   <= clamp_mag(in_centre_x, leader_x_r);
      ly_r   <= clamp_mag(in_centre_y, leader_y_r);
      last_r <= in_last_pair;
    end
  end

  // Squares, root steps and divide
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQX: d2_r <= prod;
      OP_SQY: d2_r <= d2_r + prod;
      OP_LSX: l2_r <= prod;
      OP_LSY: l2_r <= l2_r + prod;
      OP_CDSQ: begin
        cd2_r <= prod;
        rad_r <= d2_r[ROOT_W-1:0];
        res_r <= '0;
        bit_r <= ROOT_BIT0;
      end
      OP_ROOT: begin
        if (rad_r >= trial) begin
          rad_r <= rad_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV: inc_r <= quot_prod[RECIP_SHIFT +: INC_W];
      default: ;
    endcase
  end

  // Load run on first pair, add cost and mark collision on update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.accept && in_first_pair) begin
      cost_r <= in_base_cost;
      hit_r  <= 1'b0;
    end else if (cmd.op == OP_UPDATE) begin
      if ((d2_r < NEAR_LIMIT_SQ) && !near_leader) begin
        cost_r <= cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];
      end
      if (d2_r <= cd2_r) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_collided  <= hit_r;
      out_path_cost <= cost_r;
    end
  end

  assign st.skip = hit_r && !in_first_pair;
  assign st.root_last = bit_r[0];
  assign st.last = last_r;

  // Collision mark clears only when a run starts
  a_hit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(hit_r) |-> $past(cmd.accept && in_first_pair))
    else $error("collision mark dropped mid run");

  // Cost never decreases on an update
  a_cost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_UPDATE && !cmd.accept) |=> (cost_r >= $past(cost_r)))
    else $error("cost decreased on update");

endmodule
`default_nettype wire

// File: sv/path_obstacle_collision_check.sv
// An evaluated transaction squares both path axes, both leader axes and the collision
// distance, then runs the one-bit-per-cycle root, the divide, the update and emit. A
// closing pair loads the result register in emit, which waits on a pending result; a
// collided run skips to emit. One transaction at a time, set by the shared multiplier.
// Reset (rst_n, synchronous, active low) restores configuration defaults, clears cost
// and collision state, and leaves the block ready with no result pending.
`default_nettype none
module path_obstacle_collision_check
  import poc_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_path_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_path_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_corner_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_centre_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_centre_y,
  input  wire logic [COST_W-1:0]             in_base_cost,
  input  wire logic                          in_first_pair,
  input  wire logic                          in_last_pair,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_collided,
  output logic [COST_W-1:0]                  out_path_cost
);

  poc_cmd_t  cmd;
  poc_stat_t st;

  // Sequence each transaction
  poc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic and run state
  poc_dpath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_path_x     (in_path_x),
    .in_path_y     (in_path_y),
    .in_corner_x   (in_corner_x),
    .in_corner_y   (in_corner_y),
    .in_centre_x   (in_centre_x),
    .in_centre_y   (in_centre_y),
    .in_base_cost  (in_base_cost),
    .in_first_pair (in_first_pair),
    .in_last_pair  (in_last_pair),
    .out_collided  (out_collided),
    .out_path_cost (out_path_cost),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
`default_nettype wire

// File: sim/path_cost_checker.sv
// Checker for the path obstacle collision check: mirrors registers, predicts run results, compares.
`timescale 1ns / 100ps
module path_cost_checker
  import poc_pkg::*;
#(
  parameter int COORD_W = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_path_x,
  input  logic signed [COORD_W-1:0] in_path_y,
  input  logic signed [COORD_W-1:0] in_corner_x,
  input  logic signed [COORD_W-1:0] in_corner_y,
  input  logic signed [COORD_W-1:0] in_centre_x,
  input  logic signed [COORD_W-1:0] in_centre_y,
  input  logic [COST_W-1:0]         in_base_cost,
  input  logic                      in_first_pair,
  input  logic                      in_last_pair,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_collided,
  input  logic [COST_W-1:0]         out_path_cost,
  output int                        mismatch_count,
  output int                        runs_pending
);

  // Thresholds in 1/256 m, compared as squares
  localparam longint NEAR_RANGE = 896;
  localparam longint LEADER_RANGE = 512;
  localparam longint AXIS_MAX = 65536;
  localparam longint COST_MAX = 64'hFFFF_FFFF;
  localparam logic [15:0] COLL_DIST_DEFAULT = 16'd512;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic              collided;
    logic [COST_W-1:0] cost;
  } run_result_t;

  run_result_t expected_runs[$];

  // Register mirror and run state
  logic [15:0]               coll_dist;
  logic                      follow_on;
  logic signed [COORD_W-1:0] lead_x;
  logic signed [COORD_W-1:0] lead_y;
  logic [COST_W-1:0]         cost_acc;
  logic                      hit;
  int                        errors = 0;

  // Absolute axis difference, clamped to 256 m
  function automatic longint axis_gap(longint a, longint b);
    longint d;
    d = (a > b) ? a - b : b - a;
    return (d > AXIS_MAX) ? AXIS_MAX : d;
  endfunction

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    longint gx;
    longint gy;
    gx = axis_gap(ax, bx);
    gy = axis_gap(ay, by);
    return gx * gx + gy * gy;
  endfunction

  // Largest r with r*r <= v; v stays below 3.5 m squared here
  function automatic longint floor_root(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      t = r + (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Fold one accepted pair into the run state; queue the run result on the closing pair
  function automatic void apply_pair();
    longint      d2;
    longint      sum;
    logic        shielded;
    run_result_t closing;
    if (in_first_pair) begin
      cost_acc = in_base_cost;
      hit = 1'b0;
    end
    if (!hit) begin
      d2 = sq_dist(in_path_x, in_path_y, in_corner_x, in_corner_y);
      if (d2 < NEAR_RANGE * NEAR_RANGE) begin
        shielded = follow_on &&
                   (sq_dist(in_centre_x, in_centre_y, lead_x, lead_y) <
                    LEADER_RANGE * LEADER_RANGE);
        if (!shielded) begin
          sum = longint'(cost_acc) + floor_root(d2) / 3;
          cost_acc = (sum > COST_MAX) ? '1 : COST_W'(sum);
        end
      end
      if (d2 <= longint'(coll_dist) * longint'(coll_dist)) hit = 1'b1;
    end
    if (in_last_pair) begin
      closing.collided = hit;
      closing.cost = cost_acc;
      expected_runs.insert(expected_runs.size(), closing);
    end
  endfunction

  // Compare one result transaction with the oldest expected run
  function automatic void check_run();
    run_result_t want;
    if (expected_runs.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: result with nothing expected: collided %0b path_cost %0h",
                 $realtime, out_collided, out_path_cost);
      return;
    end
    want = expected_runs.pop_front();
    if (out_collided !== want.collided || out_path_cost !== want.cost) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: run mismatch: collided exp %0b got %0b, path_cost exp %0h got %0h",
                 $realtime, want.collided, out_collided, want.cost, out_path_cost);
    end
  endfunction

  // Track registers, predict on input transactions, check on output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      coll_dist = COLL_DIST_DEFAULT;
      follow_on = 1'b0;
      lead_x = '0;
      lead_y = '0;
      cost_acc = '0;
      hit = 1'b0;
      expected_runs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COLL_DIST: coll_dist = cfg_data[15:0];
          REG_FOLLOW:    follow_on = cfg_data[0];
          REG_LEADER_X:  lead_x = cfg_data;
          REG_LEADER_Y:  lead_y = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_run();
      if (in_valid && in_ready) apply_pair();
    end
    mismatch_count <= errors;
    runs_pending <= expected_runs.size();
  end

endmodule

// File: sim/path_obstacle_collision_check_test.sv
// Testbench top for the path obstacle collision check: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module path_obstacle_collision_check_test
  import poc_pkg::*;
();

  localparam int COORD_W = 24;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t            px, py, cx, cy, ox, oy;
    logic [COST_W-1:0] base;
    logic              first;
    logic              last;
  } pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  coord_t               in_path_x, in_path_y, in_corner_x, in_corner_y;
  coord_t               in_centre_x, in_centre_y;
  logic [COST_W-1:0]    in_base_cost;
  logic                 in_first_pair;
  logic                 in_last_pair;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_collided;
  logic [COST_W-1:0]    out_path_cost;

  int     mismatch_count;
  int     runs_pending;
  int     quiet = 0;
  int     items_sent = 0;
  bit     steady = 1'b0;
  bit     hold_wanted = 1'b0;
  coord_t lead_x_set = '0;
  coord_t lead_y_set = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  path_obstacle_collision_check #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_path_x    (in_path_x),
    .in_path_y    (in_path_y),
    .in_corner_x  (in_corner_x),
    .in_corner_y  (in_corner_y),
    .in_centre_x  (in_centre_x),
    .in_centre_y  (in_centre_y),
    .in_base_cost (in_base_cost),
    .in_first_pair(in_first_pair),
    .in_last_pair (in_last_pair),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_collided (out_collided),
    .out_path_cost(out_path_cost)
  );

  path_cost_checker #(
    .COORD_W(COORD_W)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_path_x     (in_path_x),
    .in_path_y     (in_path_y),
    .in_corner_x   (in_corner_x),
    .in_corner_y   (in_corner_y),
    .in_centre_x   (in_centre_x),
    .in_centre_y   (in_centre_y),
    .in_base_cost  (in_base_cost),
    .in_first_pair (in_first_pair),
    .in_last_pair  (in_last_pair),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_collided  (out_collided),
    .out_path_cost (out_path_cost),
    .mismatch_count(mismatch_count),
    .runs_pending  (runs_pending)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 80);
  endfunction

  function automatic pair_t mk_pair(int px, int py, int cx, int cy, int ox, int oy,
                                    logic [COST_W-1:0] base, logic first, logic last);
    pair_t p;
    p.px = coord_t'(px);
    p.py = coord_t'(py);
    p.cx = coord_t'(cx);
    p.cy = coord_t'(cy);
    p.ox = coord_t'(ox);
    p.oy = coord_t'(oy);
    p.base = base;
    p.first = first;
    p.last = last;
    return p;
  endfunction

  // Point within a square of the given half width, wrapping at the coordinate range
  function automatic coord_t near(coord_t origin, int spread);
    coord_t offset;
    offset = coord_t'($urandom_range(0, 2 * spread) - spread);
    return origin + offset;
  endfunction

  function automatic pair_t random_pair(logic first, logic last);
    pair_t p;
    int    r;
    p.px = coord_t'($urandom);
    p.py = coord_t'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) begin
      p.cx = p.px;
      p.cy = p.py;
    end else if (r < 3) begin
      p.cx = coord_t'($urandom);
      p.cy = coord_t'($urandom);
    end else if (r < 9) begin
      p.cx = near(p.px, 400);
      p.cy = near(p.py, 400);
    end else begin
      p.cx = near(p.px, 1000);
      p.cy = near(p.py, 1000);
    end
    if ($urandom_range(0, 1)) begin
      p.ox = near(lead_x_set, 700);
      p.oy = near(lead_y_set, 700);
    end else begin
      p.ox = coord_t'($urandom);
      p.oy = coord_t'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r == 0) p.base = '0;
    else if (r == 1) p.base = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    else p.base = $urandom;
    p.first = first;
    p.last = last;
    return p;
  endfunction

  // Offer one transaction and hold it until accepted, then idle at random
  task automatic send_pair(input pair_t p);
    int gap;
    in_valid <= 1'b1;
    in_path_x <= p.px;
    in_path_y <= p.py;
    in_corner_x <= p.cx;
    in_corner_y <= p.cy;
    in_centre_x <= p.ox;
    in_centre_y <= p.oy;
    in_base_cost <= p.base;
    in_first_pair <= p.first;
    in_last_pair <= p.last;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected run, then let the datapath drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] cd, logic fol, coord_t lx, coord_t ly);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_COLL_DIST;
    cfg_data <= COORD_W'(cd);
    @(posedge clk);
    cfg_index <= REG_FOLLOW;
    cfg_data <= COORD_W'(fol);
    @(posedge clk);
    cfg_index <= REG_LEADER_X;
    cfg_data <= lx;
    @(posedge clk);
    cfg_index <= REG_LEADER_Y;
    cfg_data <= ly;
    @(posedge clk);
    cfg_we <= 1'b0;
    lead_x_set = lx;
    lead_y_set = ly;
  endtask

  // Mostly well-formed runs; some lack an opening or closing mark, some have scrambled marks
  task automatic random_run(int max_len);
    int len;
    int kind;
    len = $urandom_range(1, max_len);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: send_pair(random_pair(1'b0, i == len - 1));
        1: send_pair(random_pair(i == 0, 1'b0));
        2: send_pair(random_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        default: send_pair(random_pair(i == 0, i == len - 1));
      endcase
      items_sent++;
    end
  endtask

  task automatic random_phase(int target, int max_len);
    int start;
    start = items_sent;
    while (items_sent - start < target) random_run(max_len);
  endtask

  // Result side: random stalls, plus one long hold-off when requested
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (hold_wanted) begin
        stall = HOLD_CYCLES;
        hold_wanted = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_COLL_DIST;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_path_x <= '0;
    in_path_y <= '0;
    in_corner_x <= '0;
    in_corner_y <= '0;
    in_centre_x <= '0;
    in_centre_y <= '0;
    in_base_cost <= '0;
    in_first_pair <= 1'b0;
    in_last_pair <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 3 m and 895 add cost, exactly 3.5 m adds nothing
    send_pair(mk_pair(0, 0, 768, 0, 0, 0, 32'd1000, 1'b1, 1'b0));
    send_pair(mk_pair(100, 100, 995, 100, 0, 0, 32'd0, 1'b0, 1'b0));
    send_pair(mk_pair(0, 0, 0, 896, 0, 0, 32'd0, 1'b0, 1'b0));
    // exactly at the collision distance counts as collided
    send_pair(mk_pair(0, 0, 512, 0, 0, 0, 32'd0, 1'b0, 1'b1));
    // zero distance collides; the rest of the run is dropped but still closes
    send_pair(mk_pair(5, 5, 5, 5, 0, 0, 32'd0, 1'b1, 1'b0));
    send_pair(mk_pair(0, 0, 100, 0, 0, 0, 32'd0, 1'b0, 1'b1));
    // opposite extremes clamp; a near pair at the extremes saturates cost; single-pair runs
    send_pair(mk_pair(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608,
                      32'hFFFF_FFFF, 1'b1, 1'b1));
    send_pair(mk_pair(8388607, -8388608, 8388007, -8388208, 0, 0,
                      32'hFFFF_FF80, 1'b1, 1'b1));
    // no opening mark: continue on the finished run's state; then 0 and 513 single-pair runs
    send_pair(mk_pair(0, 0, 300, 400, 0, 0, 32'd77, 1'b0, 1'b1));
    send_pair(mk_pair(0, 0, 10, 0, 0, 0, 32'd5, 1'b0, 1'b1));
    send_pair(mk_pair(-1, -1, -1, -1, -1, -1, 32'd0, 1'b1, 1'b1));
    send_pair(mk_pair(0, 0, 513, 0, 0, 0, 32'd9, 1'b1, 1'b1));

    // Follow mode, zero collision distance: centre near the leader suppresses cost
    program_regs(16'd0, 1'b1, coord_t'(1000), coord_t'(-1000));
    send_pair(mk_pair(0, 0, 600, 0, 1511, -1000, 32'd50, 1'b1, 1'b0));
    send_pair(mk_pair(0, 0, 600, 0, 1512, -1000, 32'd0, 1'b0, 1'b0));
    send_pair(mk_pair(0, 0, 0, 300, 1300, -1300, 32'd0, 1'b0, 1'b0));
    send_pair(mk_pair(7, 7, 7, 7, -8388608, 8388607, 32'd0, 1'b0, 1'b1));

    // Largest collision distance, on and just past the boundary
    program_regs(16'hFFFF, 1'b0, coord_t'(-8388608), coord_t'(8388607));
    send_pair(mk_pair(0, 0, 65535, 0, 0, 0, 32'd12345, 1'b1, 1'b1));
    send_pair(mk_pair(0, 0, 65535, 1, 0, 0, 32'd54321, 1'b1, 1'b1));

    // Random runs over several register settings
    program_regs(16'd0, 1'b1, coord_t'(-8388608), coord_t'(-8388608));
    random_phase(110, 4);
    program_regs(16'hFFFF, 1'b0, coord_t'(8388607), coord_t'(8388607));
    random_phase(60, 1);
    program_regs(16'($urandom_range(0, 900)), 1'b1, coord_t'($urandom), coord_t'($urandom));
    hold_wanted = 1'b1;
    random_phase(130, 5);
    program_regs(16'd512, 1'b1, coord_t'($urandom), coord_t'($urandom));
    random_phase(130, 6);
    steady = 1'b1;
    program_regs(16'($urandom_range(0, 1200)), 1'($urandom_range(0, 1)),
                 coord_t'($urandom), coord_t'($urandom));
    random_phase(110, 4);

    settle();
    if (mismatch_count == 0 && runs_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
